@@ hdl/pfba_pkg.sv @@
// ----------------------------------------------------------------------------
// pfba_pkg: shared types and constants for the page frame allocator
// Action and status codes, field widths and the controller command bundle.
// ----------------------------------------------------------------------------
package pfba_pkg;

  // Field widths
  localparam int unsigned RSV_W       = 15;  // reserve_last
  localparam int unsigned ADDR_W      = 27;  // frame_address
  localparam int unsigned FRAME_SHIFT = 12;  // 4 KiB frames
  localparam int unsigned IDX_W       = ADDR_W - FRAME_SHIFT;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;

  // Action codes (s_axis_tuser)
  localparam logic ACT_CLEAR = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  // Status codes (m_axis_tuser)
  localparam logic STS_DONE = 1'b0;
  localparam logic STS_FULL = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;  // latch the incoming request
    logic run;  // execute latched request, load result register
  } cmd_t;

endpackage

@@ hdl/pfba_ctrl.sv @@
// ----------------------------------------------------------------------------
// pfba_ctrl: sequencing for the page frame allocator
// Takes one request at a time, runs it once the result register is free.
// ----------------------------------------------------------------------------
module pfba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output pfba_pkg::cmd_t cmd_o
);
  import pfba_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // result register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          cmd_o.run   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a request is only executed after it was latched
  a_run_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.run |-> (state_q == ST_EXEC))
    else $error("run issued outside EXEC");

  // executing never overwrites an undelivered result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.run |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

@@ hdl/pfba_dpath.sv @@
// ----------------------------------------------------------------------------
// pfba_dpath: allocation state and result datapath
// Lowest-first allocation after a prefix reserve always leaves the used
// frames as one contiguous run from frame 0, so the bitmap is held as a
// fill count: frames below used_cnt_q are used, the rest free.
// ----------------------------------------------------------------------------
module pfba_dpath #(
  parameter int unsigned FRAME_COUNT = 32768
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pfba_pkg::cmd_t                cmd_i,
  input  logic                          action_i,
  input  logic [pfba_pkg::RSV_W-1:0]    reserve_last_i,
  output logic [pfba_pkg::ADDR_W-1:0]   frame_address_o,
  output logic                          status_o
);
  import pfba_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_COUNT + 1);
  localparam int unsigned CMP_W = (CNT_W > RSV_W + 1) ? CNT_W : RSV_W + 1;
  localparam int unsigned EXT_W = CNT_W + IDX_W;

  logic              action_q;
  logic [RSV_W-1:0]  rsv_q;
  logic [CNT_W-1:0]  used_cnt_q, used_cnt_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              sts_q, sts_d;

  logic [CMP_W-1:0]  rsv_ext;
  logic              full;
  logic [EXT_W-1:0]  idx_ext;

  assign rsv_ext = CMP_W'(rsv_q);
  assign full    = (used_cnt_q == CNT_W'(FRAME_COUNT));
  assign idx_ext = EXT_W'(used_cnt_q);

  always_comb begin
    used_cnt_d = used_cnt_q;
    addr_d     = '0;
    sts_d      = STS_DONE;
    case (action_q)
      ACT_CLEAR: begin
        // a reserve reaching or past the last frame marks every frame used
        if (rsv_ext >= CMP_W'(FRAME_COUNT - 1)) begin
          used_cnt_d = CNT_W'(FRAME_COUNT);
        end else begin
          used_cnt_d = CNT_W'(rsv_ext + 1'b1);
        end
      end
      ACT_ALLOC: begin
        if (full) begin
          sts_d = STS_FULL;
        end else begin
          used_cnt_d = used_cnt_q + 1'b1;
          // address wraps to the field width
          addr_d     = {idx_ext[IDX_W-1:0], {FRAME_SHIFT{1'b0}}};
        end
      end
      default: begin
        sts_d = STS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_cnt_q <= '0;
    end else if (cmd_i.run) begin
      used_cnt_q <= used_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      action_q <= action_i;
      rsv_q    <= reserve_last_i;
    end
    if (cmd_i.run) begin
      addr_q <= addr_d;
      sts_q  <= sts_d;
    end
  end

  assign frame_address_o = addr_q;
  assign status_o        = sts_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_cnt_q <= CNT_W'(FRAME_COUNT))
    else $error("fill count beyond frame count");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.run && action_q == ACT_ALLOC && !full) |=>
      (used_cnt_q == $past(used_cnt_q) + 1'b1 && sts_q == STS_DONE))
    else $error("allocate did not claim exactly one frame");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.run && action_q == ACT_ALLOC && full) |=>
      (sts_q == STS_FULL && $stable(used_cnt_q)))
    else $error("failed allocate changed state");

endmodule

@@ hdl/page_frame_bitmap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core: physical page frame allocator
// Hands out 4 KiB frames lowest first; a clear request reserves low frames.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on s_axis: tuser selects clear (0) or allocate (1),
//   tdata carries the last reserved frame for a clear. Every request gives
//   exactly one result on m_axis: tdata the frame byte address (frame * 4096,
//   27 bits, 0 on clear or failure), tuser the status (1 = no free frame).
//   Sequence: the controller latches a request in its IDLE state, then
//   executes it in EXEC once the output register is free, loading the result.
//   The latch/execute sequence of the controller takes one request at a
//   time, so one request is in flight at a time.
//   The result sits in an output register, so a new request is latched
//   while the previous result waits; a stalled m_axis_tready holds the
//   result and blocks execution of the next request until it is taken.
//   Reset: all frames free, no result pending. State is a fill count,
//   so there is no clearing pass; a clear request runs the same latch/execute sequence.
// ----------------------------------------------------------------------------
module page_frame_bitmap_allocator_core #(
  parameter int unsigned FRAME_COUNT = 32768
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [pfba_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [14:0] reserve_last, [15] 0
  input  logic                                s_axis_tuser,   // [0] action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [pfba_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // [26:0] frame_address, [31:27] 0
  output logic                                m_axis_tuser    // [0] status
);
  import pfba_pkg::*;

  cmd_t              cmd;
  logic [ADDR_W-1:0] frame_address;

  pfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  pfba_dpath #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (s_axis_tuser),
    .reserve_last_i  (s_axis_tdata[RSV_W-1:0]),
    .frame_address_o (frame_address),
    .status_o        (m_axis_tuser)
  );

  assign m_axis_tdata = OUT_TDATA_W'(frame_address);

endmodule
